@@ rtl/utf16_to_utf8_transcoder_top_defines.svh @@
// Assertion macros shared by the transcoder RTL files.
// Depends on nothing; files that check their own logic include this header.
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/utt_pkg.sv @@
// Package for the UTF-16 to UTF-8 transcoder: transaction payload types,
// the job record passed from front to back, and the UTF-8 encoding helpers.
package utt_pkg;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        final_unit;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       run_end;
      logic       string_end;
   } rsp_payload_type;

   typedef struct packed {
      logic        has_repl;
      logic        has_cp;
      logic [20:0] cp;
      logic        final_unit;
   } job_type;

   localparam logic [20:0] REPL_CP      = 21'h00FFFD;
   localparam logic [20:0] SUPP_BASE    = 21'h010000;
   localparam logic [15:0] HIGH_SUR_MIN = 16'hD800;
   localparam logic [15:0] HIGH_SUR_MAX = 16'hDBFF;
   localparam logic [15:0] LOW_SUR_MIN  = 16'hDC00;
   localparam logic [15:0] LOW_SUR_MAX  = 16'hDFFF;

   localparam logic [1:0] LEN_ONE   = 2'd0;
   localparam logic [1:0] LEN_TWO   = 2'd1;
   localparam logic [1:0] LEN_THREE = 2'd2;
   localparam logic [1:0] LEN_FOUR  = 2'd3;

   function automatic logic [1:0] utt_len_code(input logic [20:0] cp);
      logic [1:0] code;
      if (cp[20:7] == 14'd0) begin
         code = LEN_ONE;
      end else if (cp[20:11] == 10'd0) begin
         code = LEN_TWO;
      end else if (cp[20:16] == 5'd0) begin
         code = LEN_THREE;
      end else begin
         code = LEN_FOUR;
      end
      return code;
   endfunction

   function automatic logic [7:0] utt_byte(input logic [20:0] cp, input logic [1:0] len_code,
                                           input logic [1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (len_code)
         LEN_ONE: begin
            b = {1'b0, cp[6:0]};
         end
         LEN_TWO: begin
            b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         end
         LEN_THREE: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

@@ rtl/utt_front.sv @@
// Front end of the transcoder: accepts code units, pairs surrogates and
// pushes one job per transaction that yields bytes. Depends on utt_pkg.
module utt_front
   import utt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            queue_full,
   output logic            push,
   output job_type         push_job
);

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_high_ff, held_high_in;
   logic       accept;
   logic       is_high, is_low;
   logic [15:0] unit;
   job_type    job;

   assign unit    = req_payload.code_unit;
   assign is_high = (unit >= HIGH_SUR_MIN) && (unit <= HIGH_SUR_MAX);
   assign is_low  = (unit >= LOW_SUR_MIN) && (unit <= LOW_SUR_MAX);

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      job.has_repl   = 1'b0;
      job.has_cp     = 1'b0;
      job.cp         = {5'd0, unit};
      job.final_unit = req_payload.final_unit;
      held_valid_in  = held_valid_ff;
      held_high_in   = held_high_ff;
      if (accept) begin
         held_valid_in = 1'b0;
         held_high_in  = 10'd0;
         if (held_valid_ff && is_low) begin
            job.has_cp = 1'b1;
            job.cp     = SUPP_BASE + {1'b0, held_high_ff, unit[9:0]};
         end else begin
            job.has_repl = held_valid_ff;
            if (is_high && !req_payload.final_unit) begin
               held_valid_in = 1'b1;
               held_high_in  = unit[9:0];
            end else if (is_high || is_low) begin
               job.has_cp = 1'b1;
               job.cp     = REPL_CP;
            end else begin
               job.has_cp = 1'b1;
            end
         end
      end
   end

   assign push     = accept && (job.has_repl || job.has_cp);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_high_ff  <= 10'd0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_high_ff  <= held_high_in;
      end
   end

endmodule

@@ rtl/utt_queue.sv @@
// Job queue between the front and back ends of the transcoder.
// Register-based FIFO; depends on utt_pkg and the assertion macro header.
`include "utf16_to_utf8_transcoder_top_defines.svh"
module utt_queue
   import utt_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   `UTT_ASSERT_SAME(a_no_overflow, clock, reset, push, !full, "Push into a full job queue.")
   `UTT_ASSERT_SAME(a_no_underflow, clock, reset, pop, not_empty, "Pop from an empty job queue.")
   `UTT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "Queue count out of range.")
   `UTT_ASSERT_SAME(a_ptr_agree, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "Empty queue with unequal pointers.")

endmodule

@@ rtl/utt_back.sv @@
// Back end of the transcoder: takes jobs from the queue and serializes
// their UTF-8 bytes into the output register. Depends on utt_pkg and macros.
`include "utf16_to_utf8_transcoder_top_defines.svh"
module utt_back
   import utt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  job_type         head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam logic PHASE_REPL = 1'b0;
   localparam logic PHASE_CP   = 1'b1;

   logic            cur_valid_ff, cur_valid_in;
   job_type         cur_ff, cur_in;
   logic            phase_ff, phase_in;
   logic [1:0]      idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            out_ready, emit, phase_last, job_last;
   logic [1:0]      cp_len;
   logic [7:0]      next_byte;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign emit      = cur_valid_ff && out_ready;
   assign cp_len    = utt_len_code(cur_ff.cp);

   always_comb begin
      if (phase_ff == PHASE_REPL) begin
         next_byte  = utt_byte(REPL_CP, LEN_THREE, idx_ff);
         phase_last = (idx_ff == LEN_THREE);
         job_last   = phase_last && !cur_ff.has_cp;
      end else begin
         next_byte  = utt_byte(cur_ff.cp, cp_len, idx_ff);
         phase_last = (idx_ff == cp_len);
         job_last   = phase_last;
      end
   end

   assign pop = head_valid && (!cur_valid_ff || (emit && job_last));

   always_comb begin
      cur_valid_in   = cur_valid_ff;
      cur_in         = cur_ff;
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.utf8_byte  = next_byte;
         rsp_payload_in.run_end    = job_last;
         rsp_payload_in.string_end = job_last && cur_ff.final_unit;
         if (phase_last) begin
            phase_in = PHASE_CP;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
         if (job_last) begin
            cur_valid_in = 1'b0;
         end
      end
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_in       = head;
         phase_in     = head.has_repl ? PHASE_REPL : PHASE_CP;
         idx_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PHASE_REPL;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `UTT_ASSERT_SAME(a_job_nonempty, clock, reset, cur_valid_ff, cur_ff.has_repl || cur_ff.has_cp, "Active job produces no bytes.")
   `UTT_ASSERT_SAME(a_cp_phase, clock, reset, cur_valid_ff && phase_ff == PHASE_CP, cur_ff.has_cp, "Code point phase without a code point.")
   `UTT_ASSERT_SAME(a_string_end, clock, reset, rsp_valid_ff && rsp_payload_ff.string_end, rsp_payload_ff.run_end, "String end without run end.")

endmodule

@@ rtl/utf16_to_utf8_transcoder_top.sv @@
// Top level of the UTF-16 to UTF-8 transcoder: front end, job queue and
// back end. Depends on utt_pkg, utt_front, utt_queue and utt_back.
//
// Each request transaction carries one UTF-16 code unit; each response
// transaction carries one UTF-8 byte, with run_end on the last byte caused by
// a request and string_end on the last byte of a string. The front end takes
// one request per cycle while the job queue has room, pairing surrogates and
// turning unpaired ones into U+FFFD; a request that opens a pair yields no
// bytes. The back end serializes one byte per cycle while the output is not
// stalled; a request produces zero to six bytes, one to three for typical
// text. The byte serializer sets the sustained rate; the job queue of
// QUEUE_DEPTH entries absorbs short bursts. The first byte of a request passes
// through a queue slot, the current job register and the output register.
module utf16_to_utf8_transcoder_top
   import utt_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic    push, pop, queue_full, queue_not_empty;
   job_type push_job, head_job;

   utt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   utt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head_job)
   );

   utt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (queue_not_empty),
      .head        (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
